>>> rtl/ovl_pkg.sv
package ovl_pkg;

  localparam int ValueWidth    = 32;
  localparam int CountOutWidth = 7;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT,
    ACT_PUSH_BACK,
    ACT_REMOVE,
    ACT_FIND
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

>>> rtl/ovl_ram.sv
module ovl_ram
  import ovl_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [ValueWidth-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [ValueWidth-1:0] rdata
);

  logic [ValueWidth-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ordered_value_list.sv
// Bounded ordered list in a ring buffer, one entry per memory slot.
// Insert: the result is registered from the insert state once the output is free; the next
// transaction is taken in the idle state that follows. Remove/find: one memory read per cycle
// from the front, a find stops at its first match, a remove closes the gap in the same pass.
// One transaction at a time; in_ready returns with out_valid; output stalls add cycles.
// Reset (sync, active high) empties the list; slot contents are not cleared.
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   action,
  input  logic signed [ValueWidth-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic                         refused,
  output logic [CountOutWidth-1:0]     entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t                state, state_next;
  action_t               act, act_next;
  logic [ValueWidth-1:0] val, val_next;
  logic [AW-1:0]         front, front_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         rd_pos, rd_pos_next;
  logic [AW-1:0]         rd_slot, rd_slot_next;
  logic                  pend, pend_next;
  logic [AW-1:0]         pend_slot, pend_slot_next;
  logic                  found, found_next;
  logic [AW-1:0]         wr_slot, wr_slot_next;
  logic                  hit_r, hit_r_next;
  logic                  out_valid_next;
  logic                  hit_next, refused_next;
  logic [CountOutWidth-1:0] entry_count_next;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ValueWidth-1:0] mem_wdata;
  logic [ValueWidth-1:0] mem_rdata;

  logic                  out_free;
  logic                  full;
  logic [AW-1:0]         front_dec;
  logic [AW:0]           back_sum;
  logic [AW-1:0]         back_slot;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] s);
    wrap_inc = (s == AW'(CAPACITY - 1)) ? '0 : s + AW'(1);
  endfunction

  ovl_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rd_slot),
    .rdata(mem_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign full      = (count == CW'(CAPACITY));
  assign front_dec = (front == '0) ? AW'(CAPACITY - 1) : front - AW'(1);
  assign back_sum  = (AW+1)'(front) + (AW+1)'(count);
  assign back_slot = (back_sum >= (AW+1)'(CAPACITY)) ?
                     AW'(back_sum - (AW+1)'(CAPACITY)) : AW'(back_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act         <= act_next;
    val         <= val_next;
    rd_pos      <= rd_pos_next;
    rd_slot     <= rd_slot_next;
    pend_slot   <= pend_slot_next;
    found       <= found_next;
    wr_slot     <= wr_slot_next;
    hit_r       <= hit_r_next;
    hit         <= hit_next;
    refused     <= refused_next;
    entry_count <= entry_count_next;
  end

  always_comb begin
    state_next       = state;
    act_next         = act;
    val_next         = val;
    front_next       = front;
    count_next       = count;
    rd_pos_next      = rd_pos;
    rd_slot_next     = rd_slot;
    pend_next        = 1'b0;
    pend_slot_next   = pend_slot;
    found_next       = found;
    wr_slot_next     = wr_slot;
    hit_r_next       = hit_r;
    out_valid_next   = out_valid && !out_ready;
    hit_next         = hit;
    refused_next     = refused;
    entry_count_next = entry_count;
    mem_we           = 1'b0;
    mem_waddr        = back_slot;
    mem_wdata        = val;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_next     = action_t'(action);
          val_next     = value;
          rd_pos_next  = '0;
          rd_slot_next = front;
          found_next   = 1'b0;
          hit_r_next   = 1'b0;
          case (action_t'(action))
            ACT_PUSH_FRONT, ACT_PUSH_BACK: state_next = S_INSERT;
            default:                       state_next = S_SCAN;
          endcase
        end
      end

      S_INSERT: begin
        if (out_free) begin
          if (!full) begin
            mem_we = 1'b1;
            if (act == ACT_PUSH_FRONT) begin
              mem_waddr  = front_dec;
              front_next = front_dec;
            end
            count_next = count + CW'(1);
          end
          out_valid_next   = 1'b1;
          hit_next         = 1'b0;
          refused_next     = full;
          entry_count_next = CountOutWidth'(full ? count : count + CW'(1));
          state_next       = S_IDLE;
        end
      end

      S_SCAN: begin
        // read issued in the cycle before its data is compared; shift writes trail by one slot
        if (rd_pos < count) begin
          rd_pos_next    = rd_pos + CW'(1);
          rd_slot_next   = wrap_inc(rd_slot);
          pend_next      = 1'b1;
          pend_slot_next = rd_slot;
        end
        if (pend) begin
          if (found) begin
            mem_we       = 1'b1;
            mem_waddr    = wr_slot;
            mem_wdata    = mem_rdata;
            wr_slot_next = pend_slot;
          end else if (mem_rdata == val) begin
            hit_r_next   = 1'b1;
            found_next   = (act == ACT_REMOVE);
            wr_slot_next = pend_slot;
            if (act != ACT_REMOVE) begin
              state_next = S_FINISH;
            end
          end
        end else if (rd_pos >= count) begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          if (found) begin
            count_next = count - CW'(1);
          end
          out_valid_next   = 1'b1;
          hit_next         = hit_r;
          refused_next     = 1'b0;
          entry_count_next = CountOutWidth'(found ? count - CW'(1) : count);
          state_next       = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/ovl_chk.sv
module ovl_chk
  import ovl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         hit,
  input logic                         refused,
  input logic [CountOutWidth-1:0]     entry_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({hit, refused, entry_count}))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && refused))
    else $error("hit and refused both set");

  // one transaction in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 127) || (int'(entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  // a refused insert means the list was full
  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && refused |-> (CAPACITY > 127) || (int'(entry_count) == CAPACITY))
    else $error("refused with room left");

endmodule

bind ordered_value_list ovl_chk #(.CAPACITY(CAPACITY)) u_ovl_chk (.*);

>>> bench/tb_ordered_value_list.sv
module tb_ordered_value_list
  import ovl_pkg::*;
();

  localparam int Capacity   = 64;
  localparam int IdleLimit  = 3000;
  localparam int DrainWait  = 2 * Capacity + 20;
  localparam int MixItems   = 300;

  typedef struct packed {
    logic                     hit;
    logic                     refused;
    logic [CountOutWidth-1:0] count;
  } list_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   action = 2'b00;
  logic signed [ValueWidth-1:0] value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         hit;
  logic                         refused;
  logic [CountOutWidth-1:0]     entry_count;

  logic [ValueWidth-1:0] list_contents[$];
  list_result_t          pending_results[$];
  logic [ValueWidth-1:0] value_pool[16];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int hit_count     = 0;
  int refused_count = 0;
  int idle_cycles   = 0;

  ordered_value_list #(.CAPACITY(Capacity)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .refused     (refused),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // list behavior: apply one transaction and return what the block must report
  function automatic list_result_t apply_list_op(action_t act, logic [ValueWidth-1:0] val);
    list_result_t res;
    int           idx;
    res = '0;
    idx = -1;
    if (act == ACT_REMOVE || act == ACT_FIND) begin
      foreach (list_contents[i]) begin
        if (idx < 0 && list_contents[i] == val) idx = i;
      end
    end
    case (act)
      ACT_PUSH_FRONT: begin
        if (list_contents.size() >= Capacity) res.refused = 1'b1;
        else list_contents.push_front(val);
      end
      ACT_PUSH_BACK: begin
        if (list_contents.size() >= Capacity) res.refused = 1'b1;
        else list_contents.push_back(val);
      end
      ACT_REMOVE: begin
        if (idx >= 0) begin
          res.hit = 1'b1;
          list_contents.delete(idx);
        end
      end
      default: begin
        res.hit = (idx >= 0);
      end
    endcase
    res.count = CountOutWidth'(list_contents.size());
    return res;
  endfunction

  // Called at a rising edge; returns at the edge the transaction is taken,
  // with in_valid still high.
  task automatic send_op(action_t act, logic [ValueWidth-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_list_op(act, val));
    sent_count++;
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50 && list_contents.size() > 0)
      return list_contents[$urandom_range(list_contents.size() - 1)];
    else if (r < 80)
      return value_pool[$urandom_range(15)];
    else
      return $urandom();
  endfunction

  function automatic action_t pick_insert();
    return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
  endfunction

  task automatic test_basic_ops();
    send_op(ACT_FIND, 32'd5);
    send_op(ACT_REMOVE, 32'd5);
    send_op(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_op(ACT_PUSH_FRONT, 32'h8000_0000);
    send_op(ACT_PUSH_BACK, 32'h0000_0000);
    send_op(ACT_PUSH_FRONT, 32'hffff_ffff);
    send_op(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_op(ACT_FIND, 32'h8000_0000);
    send_op(ACT_FIND, 32'd1);
    send_op(ACT_FIND, 32'hffff_ffff);
    send_op(ACT_FIND, 32'h7fff_ffff);
    send_op(ACT_REMOVE, 32'h7fff_ffff);
    send_op(ACT_FIND, 32'h7fff_ffff);
    send_op(ACT_REMOVE, 32'h0000_0000);
    send_op(ACT_REMOVE, 32'h0000_0000);
    send_op(ACT_REMOVE, 32'hffff_ffff);
    send_op(ACT_REMOVE, 32'h7fff_ffff);
    send_op(ACT_FIND, 32'h8000_0000);
    send_op(ACT_REMOVE, 32'h8000_0000);
    send_op(ACT_FIND, 32'h8000_0000);
    send_op(ACT_PUSH_FRONT, 32'h5555_5555);
    send_op(ACT_PUSH_BACK, 32'haaaa_aaaa);
    send_op(ACT_REMOVE, 32'haaaa_aaaa);
    send_op(ACT_REMOVE, 32'h5555_5555);
  endtask

  // fill to capacity, hit the refusal path, then drain to empty
  task automatic test_full_list();
    logic [ValueWidth-1:0] victim;
    while (list_contents.size() < Capacity) send_op(pick_insert(), pick_value());
    repeat (2) begin
      send_op(ACT_PUSH_FRONT, $urandom());
      send_op(ACT_PUSH_BACK, $urandom());
    end
    send_op(ACT_FIND, list_contents[Capacity-1]);
    send_op(ACT_FIND, list_contents[0]);
    send_op(ACT_FIND, $urandom());
    send_op(ACT_REMOVE, list_contents[Capacity-1]);
    send_op(ACT_PUSH_BACK, pick_value());
    while (list_contents.size() > 0) begin
      if ($urandom_range(9) == 0) victim = $urandom();
      else victim = list_contents[$urandom_range(list_contents.size() - 1)];
      send_op(ACT_REMOVE, victim);
    end
  endtask

  // random walk: list size drifts up or down in bursts, about half the values
  // taken from the list, the rest pool or random values, some noise
  task automatic test_random_mix(int n);
    bit      grow;
    int      r;
    action_t act;
    grow = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) grow = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 5)
        act = action_t'($urandom_range(3));
      else if (r < (grow ? 70 : 30))
        act = pick_insert();
      else
        act = $urandom_range(1) ? ACT_REMOVE : ACT_FIND;
      send_op(act, pick_value());
    end
  endtask

  task automatic run_phase(int send_pct, int stall);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    test_full_list();
    test_random_mix(MixItems);
  endtask

  always @(posedge clk) begin : check_results
    list_result_t want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction outstanding", $time);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        hit_count     += want.hit;
        refused_count += want.refused;
        if (hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0b, got %0b", $time, want.hit, hit);
          error_count++;
        end
        if (refused !== want.refused) begin
          $display("%0t: refused mismatch: expected %0b, got %0b",
                   $time, want.refused, refused);
          error_count++;
        end
        if (entry_count !== want.count) begin
          $display("%0t: entry_count mismatch: expected %0d, got %0d",
                   $time, want.count, entry_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    run_phase(0, 0);
    run_phase(55, 0);
    run_phase(0, 55);
    run_phase(25, 25);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Sent %0d transactions under four idle/stall mixes; checked %0d results",
             sent_count, checked_count);
    $display("  (%0d matches, %0d refused inserts, list filled and drained each phase)",
             hit_count, refused_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ovl_pkg.sv
rtl/ovl_ram.sv
rtl/ordered_value_list.sv
rtl/ovl_chk.sv
bench/tb_ordered_value_list.sv
